/* hdl/sap_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared types and constants: command codes, transaction payloads and the
// stored term layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sap_pkg;

  // Default number of terms each polynomial store can hold.
  localparam int unsigned TERMS_DEFAULT = 32;

  // Command codes carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_ADD    = 2'd2
  } cmd_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] coef;
    logic [15:0]        expon;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] sum_coef;
    logic [15:0]        sum_expon;
    logic               last;
    logic               empty_res;
    logic               overflow;
  } out_item_t;

  // One stored term.
  typedef struct packed {
    logic signed [31:0] coef;
    logic [15:0]        expon;
  } term_t;

endpackage : sap_pkg

`default_nettype wire

/* hdl/sparse_polynomial_add.sv */
// An add transaction merges the two loaded term lists, one merge step per cycle,
// except that a step that passes a term on, or the final result, waits while the
// output is stalled. The merge loop runs until both term memories are used up.
// Throughput: one load per cycle; input stalls while an add is merging.
// Reset: synchronous, active low; clears counts, overflow flag and control.
// ----------------------------------------------------------------------------
// Sparse polynomial adder
// Stores two term lists in synchronous memories and merges them in descending
// exponent order, adding equal-exponent coefficients with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_add #(
  parameter int unsigned TERMS_PER_POLY = sap_pkg::TERMS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sap_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sap_pkg::out_item_t     out_data
);

  import sap_pkg::*;

  localparam int unsigned AW = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam int unsigned CW = $clog2(TERMS_PER_POLY + 1);
  localparam logic [CW-1:0] FULL = CW'(TERMS_PER_POLY);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Term memories and their registered read data.
  term_t first_mem  [TERMS_PER_POLY];
  term_t second_mem [TERMS_PER_POLY];
  term_t rd_a_r, rd_b_r;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt, ib_r, ib_nxt;
  logic          overflow_r, overflow_nxt;

  // Held-back term, so the final one can be flagged last.
  logic               pend_valid_r, pend_valid_nxt;
  logic signed [31:0] pend_coef_r, pend_coef_nxt;
  logic [15:0]        pend_expon_r, pend_expon_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic in_acc, out_free;
  logic load_a, load_b, start_add;
  logic a_has, b_has, merge_done;
  logic take_a, take_b, emit;
  logic signed [31:0] new_coef;
  logic [15:0]        new_expon;
  logic signed [32:0] wide_sum;
  logic signed [31:0] sat_sum;
  logic step, finish;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_a    = in_acc && (in_data.command == CMD_LOAD_A);
  assign load_b    = in_acc && (in_data.command == CMD_LOAD_B);
  assign start_add = in_acc && (in_data.command == CMD_ADD);

  assign a_has      = (ia_r < cnt_a_r);
  assign b_has      = (ib_r < cnt_b_r);
  assign merge_done = !a_has && !b_has;

  // Saturating sum of two equal-exponent coefficients.
  assign wide_sum = {rd_a_r.coef[31], rd_a_r.coef} + {rd_b_r.coef[31], rd_b_r.coef};
  always_comb begin
    if (wide_sum[32] != wide_sum[31]) begin
      sat_sum = wide_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sum = wide_sum[31:0];
    end
  end

  // Merge step decision on the current heads of both lists.
  always_comb begin
    take_a    = 1'b0;
    take_b    = 1'b0;
    emit      = 1'b1;
    new_coef  = rd_a_r.coef;
    new_expon = rd_a_r.expon;
    if (a_has && b_has) begin
      if (rd_a_r.expon > rd_b_r.expon) begin
        take_a = 1'b1;
      end else if (rd_a_r.expon == rd_b_r.expon) begin
        take_a   = 1'b1;
        take_b   = 1'b1;
        new_coef = sat_sum;
        emit     = (sat_sum != 32'sd0);
      end else begin
        take_b    = 1'b1;
        new_coef  = rd_b_r.coef;
        new_expon = rd_b_r.expon;
      end
    end else if (a_has) begin
      take_a = 1'b1;
    end else begin
      take_b    = 1'b1;
      new_coef  = rd_b_r.coef;
      new_expon = rd_b_r.expon;
    end
  end

  // A step that would displace a held term needs the output register free.
  assign step   = (state_r == ST_MERGE) && !merge_done &&
                  (!emit || !pend_valid_r || out_free);
  assign finish = (state_r == ST_MERGE) && merge_done && out_free;

  // Next-state, index, count and output logic.
  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ia_nxt         = ia_r;
    ib_nxt         = ib_r;
    overflow_nxt   = overflow_r;
    pend_valid_nxt = pend_valid_r;
    pend_coef_nxt  = pend_coef_r;
    pend_expon_nxt = pend_expon_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (load_a) begin
          if (cnt_a_r < FULL) begin
            cnt_a_nxt = cnt_a_r + 1'b1;
          end else begin
            overflow_nxt = 1'b1;
          end
        end
        if (load_b) begin
          if (cnt_b_r < FULL) begin
            cnt_b_nxt = cnt_b_r + 1'b1;
          end else begin
            overflow_nxt = 1'b1;
          end
        end
        if (start_add) begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (step) begin
          ia_nxt = ia_r + CW'(take_a);
          ib_nxt = ib_r + CW'(take_b);
          if (emit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{sum_coef: pend_coef_r, sum_expon: pend_expon_r,
                                last: 1'b0, empty_res: 1'b0, overflow: overflow_r};
            end
            pend_valid_nxt = 1'b1;
            pend_coef_nxt  = new_coef;
            pend_expon_nxt = new_expon;
          end
        end
        if (finish) begin
          out_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_data_nxt = '{sum_coef: pend_coef_r, sum_expon: pend_expon_r,
                             last: 1'b1, empty_res: 1'b0, overflow: overflow_r};
          end else begin
            out_data_nxt = '{sum_coef: 32'sd0, sum_expon: 16'd0,
                             last: 1'b1, empty_res: 1'b1, overflow: overflow_r};
          end
          pend_valid_nxt = 1'b0;
          cnt_a_nxt      = '0;
          cnt_b_nxt      = '0;
          ia_nxt         = '0;
          ib_nxt         = '0;
          overflow_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      overflow_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      ia_r         <= ia_nxt;
      ib_r         <= ib_nxt;
      overflow_r   <= overflow_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_coef_r  <= pend_coef_nxt;
    pend_expon_r <= pend_expon_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Term memories: one write port for loads, one read port following the
  // next merge index, so the head of each list is ready every cycle.
  always_ff @(posedge clk) begin
    if (load_a && (cnt_a_r < FULL)) begin
      first_mem[cnt_a_r[AW-1:0]] <= '{coef: in_data.coef, expon: in_data.expon};
    end
    rd_a_r <= first_mem[ia_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_b && (cnt_b_r < FULL)) begin
      second_mem[cnt_b_r[AW-1:0]] <= '{coef: in_data.coef, expon: in_data.expon};
    end
    rd_b_r <= second_mem[ib_nxt[AW-1:0]];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : sparse_polynomial_add

`default_nettype wire

/* tb/tb_sparse_polynomial_add.sv */
// ----------------------------------------------------------------------------
// Sparse polynomial adder testbench
// Loads pairs of term lists through the input channel and issues add commands.
// A behavioral merge model in this file predicts the summed terms, unless a
// directed row gives its own, and each result transaction is checked field
// by field against the oldest prediction. A short directed table covers the
// saturation limits, cancellation, store overflow and the ignored command.
// Random lists follow, with random input idling and random result stalls.
// ----------------------------------------------------------------------------

module tb_sparse_polynomial_add;

  import sap_pkg::*;

  localparam int unsigned STORE_DEPTH = TERMS_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * STORE_DEPTH + 20;

  // The command code that the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One row of the directed table; copies > 1 loads a run of descending terms.
  typedef struct {
    logic [1:0]         command;
    logic signed [31:0] coef;
    logic [15:0]        expon;
    int                 copies;
    int                 coef_step;
    int                 typed;
    out_item_t          want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Merge model state.
  term_t     poly_a [STORE_DEPTH];
  term_t     poly_b [STORE_DEPTH];
  int        count_a = 0;
  int        count_b = 0;
  bit        lost_term = 1'b0;
  out_item_t sum_terms[$];

  out_item_t expected_terms[$];
  stim_row_t directed_rows[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int add_count = 0;
  int results_checked = 0;
  int unsigned cycle_count = 0;

  sparse_polynomial_add #(
    .TERMS_PER_POLY(STORE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Build one result term.
  function automatic out_item_t term_out(logic [31:0] c, logic [15:0] e, bit last, bit empty,
                                         bit ovf);
    out_item_t r;
    r.sum_coef  = c;
    r.sum_expon = e;
    r.last      = last;
    r.empty_res = empty;
    r.overflow  = ovf;
    return r;
  endfunction

  // Apply one input transaction to the merge model; an add fills sum_terms.
  function automatic void predict_item(in_item_t item);
    int               ia;
    int               ib;
    logic signed [32:0] wide;
    term_t            pick;
    bit               keep;
    out_item_t        tail;
    sum_terms.delete();
    case (item.command)
      CMD_LOAD_A: begin
        if (count_a >= STORE_DEPTH) begin
          lost_term = 1'b1;
        end else begin
          poly_a[count_a].coef  = item.coef;
          poly_a[count_a].expon = item.expon;
          count_a++;
        end
      end
      CMD_LOAD_B: begin
        if (count_b >= STORE_DEPTH) begin
          lost_term = 1'b1;
        end else begin
          poly_b[count_b].coef  = item.coef;
          poly_b[count_b].expon = item.expon;
          count_b++;
        end
      end
      CMD_ADD: begin
        ia = 0;
        ib = 0;
        while (ia < count_a || ib < count_b) begin
          keep = 1'b1;
          if (ia < count_a && ib < count_b && poly_a[ia].expon == poly_b[ib].expon) begin
            // Equal exponents: saturating sum, dropped when it cancels.
            wide = {poly_a[ia].coef[31], poly_a[ia].coef} +
                   {poly_b[ib].coef[31], poly_b[ib].coef};
            pick.expon = poly_a[ia].expon;
            if (wide[32] != wide[31]) begin
              pick.coef = wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
              pick.coef = wide[31:0];
            end
            keep = (pick.coef != 0);
            ia++;
            ib++;
          end else if (ia < count_a &&
                       (ib >= count_b || poly_a[ia].expon > poly_b[ib].expon)) begin
            pick = poly_a[ia];
            ia++;
          end else begin
            pick = poly_b[ib];
            ib++;
          end
          if (keep) begin
            sum_terms.push_back(term_out(pick.coef, pick.expon, 1'b0, 1'b0, lost_term));
          end
        end
        if (sum_terms.size() == 0) begin
          sum_terms.push_back(term_out('0, '0, 1'b1, 1'b1, lost_term));
        end else begin
          tail = sum_terms.pop_back();
          tail.last = 1'b1;
          sum_terms.push_back(tail);
        end
        count_a = 0;
        count_b = 0;
        lost_term = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [1:0] cmd, logic [31:0] c, logic [15:0] e,
                                  int copies, int coef_step, int typed, out_item_t want);
    stim_row_t row;
    row.command   = cmd;
    row.coef      = c;
    row.expon     = e;
    row.copies    = copies;
    row.coef_step = coef_step;
    row.typed     = typed;
    row.want      = want;
    directed_rows.push_back(row);
  endfunction

  function automatic void set_idling(int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default: begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endfunction

  // Send one transaction, then record what it should produce.
  task automatic issue(in_item_t item, int typed, out_item_t want);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(item);
    if (typed != 0) begin
      expected_terms.push_back(want);
    end else begin
      foreach (sum_terms[i]) expected_terms.push_back(sum_terms[i]);
    end
    if (item.command == CMD_ADD) add_count++;
    if (item.command != CMD_UNUSED) items_sent++;
  endtask

  // Compare one accepted result transaction with the oldest prediction.
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_terms.size() == 0) begin
      $error("unexpected result: sum_coef %0d sum_expon %0d last %0b", got.sum_coef,
             got.sum_expon, got.last);
      error_count++;
      return;
    end
    want = expected_terms.pop_front();
    results_checked++;
    if (got.sum_coef !== want.sum_coef) begin
      $error("sum_coef: expected %0d, got %0d", want.sum_coef, got.sum_coef);
      error_count++;
    end
    if (got.sum_expon !== want.sum_expon) begin
      $error("sum_expon: expected %0d, got %0d", want.sum_expon, got.sum_expon);
      error_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      error_count++;
    end
    if (got.empty_res !== want.empty_res) begin
      $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
      error_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
      error_count++;
    end
  endtask

  // Result side: random stall and the check of each accepted transaction.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      check_result(out_data);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb_sparse_polynomial_add failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    in_item_t    it;
    in_item_t    a_q[$];
    in_item_t    b_q[$];
    int          n_terms;
    int          role;
    int          r;
    int          seq_idx;
    int unsigned e;
    logic [31:0] c;
    out_item_t   none;

    none = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: limits, cancellation, ordering corner cases, overflow.
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 1,
            term_out(32'h0, 16'h0, 1'b1, 1'b1, 1'b0));
    add_row(CMD_LOAD_A, 32'h7fff_ffff, 16'hffff,  1, 0, 0, none);
    add_row(CMD_LOAD_B, 32'h7fff_ffff, 16'hffff,  1, 0, 0, none);
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 1,
            term_out(32'h7fff_ffff, 16'hffff, 1'b1, 1'b0, 1'b0));
    add_row(CMD_LOAD_A, 32'h8000_0000, 16'h0,     1, 0, 0, none);
    add_row(CMD_LOAD_B, 32'h8000_0000, 16'h0,     1, 0, 0, none);
    add_row(CMD_ADD,    32'hffff_ffff, 16'hffff,  1, 0, 1,
            term_out(32'h8000_0000, 16'h0, 1'b1, 1'b0, 1'b0));
    add_row(CMD_LOAD_A, 32'h0001_0000, 16'd5,     1, 0, 0, none);
    add_row(CMD_LOAD_B, 32'hffff_0000, 16'd5,     1, 0, 0, none);
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 1,
            term_out(32'h0, 16'h0, 1'b1, 1'b1, 1'b0));
    // Mixed merge with a duplicate exponent, an ignored command and a
    // list that is out of order.
    add_row(CMD_LOAD_A, 32'h0003_0000, 16'd9,     1, 0, 0, none);
    add_row(CMD_LOAD_A, 32'h0001_8000, 16'd7,     1, 0, 0, none);
    add_row(CMD_LOAD_A, 32'hfffe_0000, 16'd7,     1, 0, 0, none);
    add_row(CMD_LOAD_B, 32'h0007_0000, 16'd8,     1, 0, 0, none);
    add_row(CMD_LOAD_B, 32'h0002_0000, 16'd7,     1, 0, 0, none);
    add_row(CMD_UNUSED, 32'hffff_ffff, 16'hffff,  1, 0, 0, none);
    add_row(CMD_LOAD_B, 32'h0000_4000, 16'd12,    1, 0, 0, none);
    add_row(CMD_LOAD_A, 32'h0000_0001, 16'd2,     1, 0, 0, none);
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 0, none);
    // Full stores that cancel exactly, with one term dropped on the first.
    add_row(CMD_LOAD_A, 32'h0001_0000, 16'd1000, 33, 32'h100, 0, none);
    add_row(CMD_LOAD_B, 32'hffff_0000, 16'd1000, 32, -32'sh100, 0, none);
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 1,
            term_out(32'h0, 16'h0, 1'b1, 1'b1, 1'b1));
    // Both stores full and disjoint: the longest sum, with overflow set.
    add_row(CMD_LOAD_A, 32'h0001_0000, 16'd40000, 34, 32'h100, 0, none);
    add_row(CMD_LOAD_B, 32'hfff0_0000, 16'd50000, 33, 32'h100, 0, none);
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 0, none);
    // The flag and stores start clean again.
    add_row(CMD_ADD,    32'h0,         16'h0,     1, 0, 1,
            term_out(32'h0, 16'h0, 1'b1, 1'b1, 1'b0));

    set_idling(0);
    foreach (directed_rows[i]) begin
      for (int k = 0; k < directed_rows[i].copies; k++) begin
        it.command = directed_rows[i].command;
        it.coef    = directed_rows[i].coef + k * directed_rows[i].coef_step;
        it.expon   = 16'(directed_rows[i].expon - k);
        issue(it, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part: well-formed pairs of descending lists that share some
    // exponents, with some noise commands and some unordered lists.
    seq_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_idling(seq_idx % 4);
      n_terms = ($urandom_range(11, 0) == 0) ? $urandom_range(48, 28) : $urandom_range(7, 0);
      e = $urandom_range(65535, 0);
      a_q.delete();
      b_q.delete();
      for (int k = 0; k < n_terms; k++) begin
        role = $urandom_range(2, 0);
        c = $urandom();
        if ($urandom_range(7, 0) == 0) c = $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
        it.coef  = c;
        it.expon = e[15:0];
        if (role != 1) begin
          it.command = CMD_LOAD_A;
          a_q.push_back(it);
        end
        if (role != 0) begin
          it.command = CMD_LOAD_B;
          r = $urandom_range(9, 0);
          // Shared exponents often cancel or saturate.
          if (role == 2 && r < 4) begin
            it.coef = -c;
          end else if (role == 2 && r < 6) begin
            it.coef = c;
          end else begin
            it.coef = $urandom();
          end
          b_q.push_back(it);
        end
        e = e - $urandom_range(2 * e / (n_terms - k + 1), 0);
      end
      if (a_q.size() > 0 && $urandom_range(7, 0) == 0) begin
        a_q[$urandom_range(a_q.size() - 1, 0)].expon = 16'($urandom());
      end
      while (a_q.size() > 0 || b_q.size() > 0) begin
        if ($urandom_range(19, 0) == 0) begin
          it.command = CMD_UNUSED;
          it.coef    = $urandom();
          it.expon   = 16'($urandom());
          issue(it, 0, none);
        end
        if (b_q.size() == 0 || (a_q.size() > 0 && $urandom_range(1, 0) == 0)) begin
          it = a_q.pop_front();
        end else begin
          it = b_q.pop_front();
        end
        issue(it, 0, none);
      end
      it.command = CMD_ADD;
      it.coef    = $urandom();
      it.expon   = 16'($urandom());
      issue(it, 0, none);
      seq_idx++;
    end

    // Let the last sums drain, then watch for stray results.
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads and commands, %0d of them adds, over %0d random list pairs.",
             items_sent, add_count, seq_idx);
    $display("Checked %0d summed terms; %0d mismatches.", results_checked, error_count);
    if (error_count == 0) begin
      $display("tb_sparse_polynomial_add passed");
    end else begin
      $display("tb_sparse_polynomial_add failed");
    end
    $finish;
  end

endmodule
